[src/modbus_rtu_register_slave_core_defines.svh]
// Assertion macros used by the top level of the Modbus RTU register slave.
`ifndef MODBUS_RTU_REGISTER_SLAVE_CORE_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MRS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/mrs_pkg.sv]
// Types, constants and the CRC step shared by the Modbus RTU register slave.
package mrs_pkg;

	localparam int FRAME_BYTES_DEF   = 256;
	localparam int HOLDING_DEPTH_DEF = 256;
	localparam int INPUT_DEPTH_DEF   = 256;
	localparam int MAX_READ_REGS_DEF = 29;

	localparam logic [1:0] OP_BUS      = 2'd0;
	localparam logic [1:0] OP_INPUT_WR = 2'd1;
	localparam logic [1:0] OP_HOLD_WR  = 2'd2;
	localparam logic [1:0] OP_HOLD_RD  = 2'd3;

	localparam logic [2:0] OC_NORMAL    = 3'd0;
	localparam logic [2:0] OC_EXCEPTION = 3'd1;
	localparam logic [2:0] OC_DROPPED   = 3'd2;
	localparam logic [2:0] OC_LOCAL     = 3'd3;
	localparam logic [2:0] OC_NONE      = 3'd4;

	localparam logic [1:0] CFG_SLAVE_ID      = 2'd0;
	localparam logic [1:0] CFG_HOLDING_COUNT = 2'd1;
	localparam logic [1:0] CFG_INPUT_COUNT   = 2'd2;

	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;
	localparam logic [7:0] FC_SHORT_LIMIT  = 8'd50;

	localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'd1;
	localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'd2;
	localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;
	localparam logic [7:0] EXC_FLAG          = 8'h80;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  rx_byte;
		logic        frame_end;
		logic [7:0]  local_index;
		logic [15:0] local_value;
	} mrs_req_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic [15:0] read_value;
		logic [2:0]  outcome;
	} mrs_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LREAD, ST_CHECK, ST_DROP, ST_BODY, ST_FETCH,
		ST_CRC_LO, ST_CRC_HI, ST_WR_HI, ST_WR_LO, ST_WR_STORE
	} mrs_state_t;

	typedef enum logic [1:0] {EM_STATUS, EM_BODY, EM_CRC_LO, EM_CRC_HI} mrs_emit_t;

	typedef enum logic [1:0] {MD_EXC, MD_ECHO, MD_READ} mrs_mode_t;

	typedef struct packed {
		logic       accept;
		logic       emit;
		mrs_emit_t  emit_src;
		logic [2:0] status_oc;
		logic       emit_rv;
		logic       check;
		logic       fetch;
		logic       wr6;
		logic       fb_rd;
		logic       hi_latch;
		logic       wr_store;
		logic       clr_step;
	} mrs_cmd_t;

	typedef struct packed {
		logic out_free;
		logic clr_last;
		logic drop;
		logic exc_any;
		logic is_wr6;
		logic wr16_go;
		logic body_last;
		logic next_hi;
		logic wr_last;
	} mrs_status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/mrs_ctrl.sv]
// Controller state machine of the Modbus RTU register slave.
module mrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_operation,
	input  logic               req_frame_end,
	output logic               req_ready,
	input  mrs_pkg::mrs_status_t st,
	output mrs_pkg::mrs_cmd_t    cmd
);
	import mrs_pkg::*;

	mrs_state_t state_q, state_d;
	logic accept;

	assign req_ready = (state_q == ST_IDLE) && st.out_free;
	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (st.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (req_operation == OP_HOLD_RD) begin
						state_d = ST_LREAD;
					end else if (req_operation == OP_BUS && req_frame_end) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_LREAD: if (st.out_free) state_d = ST_IDLE;
			ST_CHECK: begin
				if (st.drop) begin
					state_d = ST_DROP;
				end else if (st.exc_any || st.is_wr6 || !st.wr16_go) begin
					state_d = ST_BODY;
				end else begin
					state_d = ST_WR_HI;
				end
			end
			ST_DROP: if (st.out_free) state_d = ST_IDLE;
			ST_BODY: begin
				if (st.out_free) begin
					if (st.body_last) begin
						state_d = ST_CRC_LO;
					end else if (st.next_hi) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: state_d = ST_BODY;
			ST_CRC_LO: if (st.out_free) state_d = ST_CRC_HI;
			ST_CRC_HI: if (st.out_free) state_d = ST_IDLE;
			ST_WR_HI: state_d = ST_WR_LO;
			ST_WR_LO: state_d = ST_WR_STORE;
			ST_WR_STORE: state_d = st.wr_last ? ST_BODY : ST_WR_HI;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_src = EM_STATUS;
		cmd.status_oc = OC_NONE;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.accept = accept;
				if (accept) begin
					unique case (req_operation) inside
						OP_BUS: begin
							cmd.emit = !req_frame_end;
							cmd.status_oc = OC_NONE;
						end
						OP_INPUT_WR, OP_HOLD_WR: begin
							cmd.emit = 1'b1;
							cmd.status_oc = OC_LOCAL;
						end
						default: cmd.emit = 1'b0;
					endcase
				end
			end
			ST_LREAD: begin
				cmd.emit = st.out_free;
				cmd.status_oc = OC_LOCAL;
				cmd.emit_rv = 1'b1;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cmd.wr6 = !st.drop && !st.exc_any && st.is_wr6;
			end
			ST_DROP: begin
				cmd.emit = st.out_free;
				cmd.status_oc = OC_DROPPED;
			end
			ST_BODY: begin
				cmd.emit = st.out_free;
				cmd.emit_src = EM_BODY;
			end
			ST_FETCH: cmd.fetch = 1'b1;
			ST_CRC_LO: begin
				cmd.emit = st.out_free;
				cmd.emit_src = EM_CRC_LO;
			end
			ST_CRC_HI: begin
				cmd.emit = st.out_free;
				cmd.emit_src = EM_CRC_HI;
			end
			ST_WR_HI: cmd.fb_rd = 1'b1;
			ST_WR_LO: begin
				cmd.fb_rd = 1'b1;
				cmd.hi_latch = 1'b1;
			end
			ST_WR_STORE: cmd.wr_store = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

[src/mrs_datapath.sv]
// Datapath of the Modbus RTU register slave: frame buffer, register memories, CRC and reply.
module mrs_datapath #(
	parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF,
	parameter int HOLDING_DEPTH = mrs_pkg::HOLDING_DEPTH_DEF,
	parameter int INPUT_DEPTH   = mrs_pkg::INPUT_DEPTH_DEF,
	parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrs_pkg::mrs_req_t    req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mrs_pkg::mrs_rsp_t    rsp_data,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	input  mrs_pkg::mrs_cmd_t    cmd,
	output mrs_pkg::mrs_status_t st
);
	import mrs_pkg::*;

	localparam int FIDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int FLEN_W = $clog2(FRAME_BYTES + 1);
	localparam int HIDX_W = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
	localparam int IIDX_W = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
	localparam int MAXD   = (HOLDING_DEPTH > INPUT_DEPTH) ? HOLDING_DEPTH : INPUT_DEPTH;
	localparam int CLR_W  = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam logic [16:0] HOLD_LIM  = 17'(HOLDING_DEPTH);
	localparam logic [16:0] INPUT_LIM = 17'(INPUT_DEPTH);
	localparam logic [15:0] MAX_RD    = 16'(MAX_READ_REGS);

	logic [7:0] slave_id_q;
	logic [8:0] holding_count_q, input_count_q;

	logic [7:0]  fbuf [FRAME_BYTES];
	logic [15:0] hold_mem [HOLDING_DEPTH];
	logic [15:0] inp_mem [INPUT_DEPTH];
	logic [7:0]  fb_rdata_q;
	logic [15:0] hold_rdata_q, inp_rdata_q;

	logic [FLEN_W-1:0] frame_len_q;
	logic              frame_ovf_q;
	logic [7:0]        hdr_q [6];
	logic [15:0]       crc_q, crc_p1_q, crc_p2_q;
	logic [7:0]        last1_q, last2_q;

	mrs_mode_t   mode_q;
	logic [7:0]  exc_code_q;
	logic [5:0]  body_len_q, pos_q;
	logic [15:0] tx_crc_q;
	logic        use_input_q, lrd_ok_q;
	logic [FIDX_W-1:0] fb_ptr_q;
	logic [HIDX_W-1:0] hptr_q;
	logic [7:0]  wr_cnt_q, hi_q;
	logic        out_valid_q;
	mrs_rsp_t    out_q, out_d;
	logic [CLR_W-1:0] clr_q;

	logic [7:0]  func;
	logic [15:0] start, qty;
	logic [16:0] cnt_h, cnt_i, cnt_rd, end_sum, fetch_idx;
	logic        is_rd, func_bad, rd_exc2, rd_exc3, wr6_exc2, wr16_short, wr16_exc2;
	logic        frame_bad, exc_any;
	logic [7:0]  exc_code_d;
	logic [5:0]  next_pos, fetch_off;
	logic [7:0]  body_byte;
	logic [15:0] rdata;
	logic        store_byte;

	logic              hw_en, hr_en, iw_en, ir_en;
	logic [HIDX_W-1:0] hw_addr, hr_addr;
	logic [IIDX_W-1:0] iw_addr, ir_addr;
	logic [15:0]       hw_data, iw_data;

	assign func  = hdr_q[1];
	assign start = {hdr_q[2], hdr_q[3]};
	assign qty   = {hdr_q[4], hdr_q[5]};

	always_comb begin
		cnt_h = (17'(holding_count_q) < HOLD_LIM) ? 17'(holding_count_q) : HOLD_LIM;
		cnt_i = (17'(input_count_q) < INPUT_LIM) ? 17'(input_count_q) : INPUT_LIM;
		is_rd = (func == FC_READ_HOLDING) || (func == FC_READ_INPUT);
		cnt_rd = (func == FC_READ_INPUT) ? cnt_i : cnt_h;
		end_sum = 17'(start) + 17'(qty);
		func_bad = !is_rd && (func != FC_WRITE_SINGLE) && (func != FC_WRITE_MULTI);
		rd_exc2 = is_rd && (qty != 16'd0) && (end_sum > cnt_rd);
		rd_exc3 = is_rd && !rd_exc2 && (qty > MAX_RD);
		wr6_exc2 = (func == FC_WRITE_SINGLE) && (17'(start) >= cnt_h);
		wr16_short = (func == FC_WRITE_MULTI)
			&& (18'(frame_len_q) < (18'd9 + {1'b0, qty, 1'b0}));
		wr16_exc2 = (func == FC_WRITE_MULTI) && (qty != 16'd0) && (end_sum > cnt_h);
		frame_bad = frame_ovf_q || (frame_len_q < FLEN_W'(2))
			|| ((frame_len_q < FLEN_W'(8)) && (func < FC_SHORT_LIMIT))
			|| (hdr_q[0] != slave_id_q)
			|| (last2_q != crc_p2_q[7:0]) || (last1_q != crc_p2_q[15:8]);
		exc_any = func_bad || rd_exc2 || rd_exc3 || wr6_exc2 || wr16_exc2;
		if (func_bad) begin
			exc_code_d = EXC_ILLEGAL_FUNC;
		end else if (rd_exc2 || wr6_exc2 || wr16_exc2) begin
			exc_code_d = EXC_ILLEGAL_ADDR;
		end else begin
			exc_code_d = EXC_ILLEGAL_VALUE;
		end
	end

	assign next_pos  = pos_q + 6'd1;
	assign fetch_off = (pos_q - 6'd3) >> 1;
	assign fetch_idx = 17'(start) + 17'(fetch_off);
	assign rdata     = use_input_q ? inp_rdata_q : hold_rdata_q;

	always_comb begin
		body_byte = 8'h00;
		case (mode_q)
			MD_EXC: begin
				case (pos_q)
					6'd0: body_byte = slave_id_q;
					6'd1: body_byte = func + EXC_FLAG;
					default: body_byte = exc_code_q;
				endcase
			end
			MD_ECHO: begin
				case (pos_q)
					6'd0: body_byte = hdr_q[0];
					6'd1: body_byte = hdr_q[1];
					6'd2: body_byte = hdr_q[2];
					6'd3: body_byte = hdr_q[3];
					6'd4: body_byte = hdr_q[4];
					default: body_byte = hdr_q[5];
				endcase
			end
			default: begin
				case (pos_q)
					6'd0: body_byte = hdr_q[0];
					6'd1: body_byte = func;
					6'd2: body_byte = {qty[6:0], 1'b0};
					default: body_byte = pos_q[0] ? rdata[15:8] : rdata[7:0];
				endcase
			end
		endcase
	end

	always_comb begin
		out_d = '0;
		out_d.outcome = (mode_q == MD_EXC) ? OC_EXCEPTION : OC_NORMAL;
		case (cmd.emit_src)
			EM_STATUS: begin
				out_d.tx_last = 1'b1;
				out_d.outcome = cmd.status_oc;
				out_d.read_value = (cmd.emit_rv && lrd_ok_q) ? hold_rdata_q : 16'h0000;
			end
			EM_BODY: out_d.tx_byte = body_byte;
			EM_CRC_LO: out_d.tx_byte = tx_crc_q[7:0];
			default: begin
				out_d.tx_byte = tx_crc_q[15:8];
				out_d.tx_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		st.out_free  = !out_valid_q || rsp_ready;
		st.clr_last  = (clr_q == CLR_W'(MAXD - 1));
		st.drop      = frame_bad || wr16_short;
		st.exc_any   = exc_any;
		st.is_wr6    = (func == FC_WRITE_SINGLE);
		st.wr16_go   = (func == FC_WRITE_MULTI) && (qty != 16'd0);
		st.body_last = (pos_q == body_len_q - 6'd1);
		st.next_hi   = (mode_q == MD_READ) && (next_pos >= 6'd3) && next_pos[0];
		st.wr_last   = ((16'(wr_cnt_q) + 16'd1) == qty);
	end

	assign store_byte = cmd.accept && (req_data.operation == OP_BUS)
		&& (frame_len_q < FLEN_W'(FRAME_BYTES));

	always_comb begin
		hw_en = 1'b0;
		hw_addr = HIDX_W'(clr_q);
		hw_data = 16'h0000;
		if (cmd.clr_step) begin
			hw_en = 17'(clr_q) < HOLD_LIM;
		end else if (cmd.accept && req_data.operation == OP_HOLD_WR) begin
			hw_en = 17'(req_data.local_index) < HOLD_LIM;
			hw_addr = HIDX_W'(req_data.local_index);
			hw_data = req_data.local_value;
		end else if (cmd.wr6) begin
			hw_en = 1'b1;
			hw_addr = HIDX_W'(start);
			hw_data = qty;
		end else if (cmd.wr_store) begin
			hw_en = 1'b1;
			hw_addr = hptr_q;
			hw_data = {hi_q, fb_rdata_q};
		end
		hr_en = 1'b0;
		hr_addr = HIDX_W'(fetch_idx);
		if (cmd.accept && req_data.operation == OP_HOLD_RD) begin
			hr_en = 1'b1;
			hr_addr = HIDX_W'(req_data.local_index);
		end else if (cmd.fetch) begin
			hr_en = 1'b1;
		end
		iw_en = 1'b0;
		iw_addr = IIDX_W'(clr_q);
		iw_data = 16'h0000;
		if (cmd.clr_step) begin
			iw_en = 17'(clr_q) < INPUT_LIM;
		end else if (cmd.accept && req_data.operation == OP_INPUT_WR) begin
			iw_en = 17'(req_data.local_index) < INPUT_LIM;
			iw_addr = IIDX_W'(req_data.local_index);
			iw_data = req_data.local_value;
		end
		ir_en = cmd.fetch;
		ir_addr = IIDX_W'(fetch_idx);
	end

	always_ff @(posedge clk) begin
		if (hw_en) hold_mem[hw_addr] <= hw_data;
		if (hr_en) hold_rdata_q <= hold_mem[hr_addr];
	end

	always_ff @(posedge clk) begin
		if (iw_en) inp_mem[iw_addr] <= iw_data;
		if (ir_en) inp_rdata_q <= inp_mem[ir_addr];
	end

	always_ff @(posedge clk) begin
		if (store_byte) fbuf[FIDX_W'(frame_len_q)] <= req_data.rx_byte;
		if (cmd.fb_rd) fb_rdata_q <= fbuf[fb_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= 8'd1;
			holding_count_q <= 9'd256;
			input_count_q <= 9'd256;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SLAVE_ID: slave_id_q <= cfg_data[7:0];
				CFG_HOLDING_COUNT: holding_count_q <= cfg_data;
				CFG_INPUT_COUNT: input_count_q <= cfg_data;
				default: slave_id_q <= slave_id_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= '0;
			frame_ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.check) begin
				frame_len_q <= '0;
				frame_ovf_q <= 1'b0;
			end else if (store_byte) begin
				frame_len_q <= frame_len_q + FLEN_W'(1);
			end else if (cmd.accept && req_data.operation == OP_BUS) begin
				frame_ovf_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clr_step) clr_q <= clr_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (store_byte) begin
			if (frame_len_q < FLEN_W'(6)) hdr_q[3'(frame_len_q)] <= req_data.rx_byte;
			crc_q <= crc_byte(crc_q, req_data.rx_byte);
			crc_p1_q <= crc_q;
			crc_p2_q <= crc_p1_q;
			last1_q <= req_data.rx_byte;
			last2_q <= last1_q;
		end
		if (cmd.check || cmd.clr_step) begin
			crc_q <= CRC_INIT;
			crc_p1_q <= CRC_INIT;
			crc_p2_q <= CRC_INIT;
		end
		if (cmd.accept && req_data.operation == OP_HOLD_RD) begin
			lrd_ok_q <= 17'(req_data.local_index) < HOLD_LIM;
		end
		if (cmd.emit) out_q <= out_d;
		if (cmd.check) begin
			if (exc_any) begin
				mode_q <= MD_EXC;
				body_len_q <= 6'd3;
			end else if (is_rd) begin
				mode_q <= MD_READ;
				body_len_q <= 6'(7'd3 + {1'b0, qty[4:0], 1'b0});
			end else begin
				mode_q <= MD_ECHO;
				body_len_q <= 6'd6;
			end
			exc_code_q <= exc_code_d;
			use_input_q <= (func == FC_READ_INPUT);
			pos_q <= '0;
			tx_crc_q <= CRC_INIT;
			fb_ptr_q <= FIDX_W'(7);
			hptr_q <= HIDX_W'(start);
			wr_cnt_q <= '0;
		end
		if (cmd.emit && cmd.emit_src == EM_BODY) begin
			pos_q <= next_pos;
			tx_crc_q <= crc_byte(tx_crc_q, body_byte);
		end
		if (cmd.fb_rd) fb_ptr_q <= fb_ptr_q + FIDX_W'(1);
		if (cmd.hi_latch) hi_q <= fb_rdata_q;
		if (cmd.wr_store) begin
			hptr_q <= hptr_q + HIDX_W'(1);
			wr_cnt_q <= wr_cnt_q + 8'd1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

[src/modbus_rtu_register_slave_core.sv]
// Top level of the Modbus RTU register slave: controller, datapath and assertions.
//
// Each request is one bus byte or one local register operation. A bus byte that does not end
// a frame and a local write each give one status result; a local holding read passes first
// through the LREAD state, as the holding memory read is registered. The byte that ends a
// frame is followed by a check state, then the reply bytes (5 to 63 bytes) or the single
// status result of a dropped frame, with a FETCH state per register read by codes 3 and 4
// and the frame-buffer states WR_HI, WR_LO and WR_STORE per register written by code 16.
// The CRC of a request is built as its bytes arrive, the reply CRC as its bytes leave.
// Results go through one output register, and a request is taken only when that register is
// empty or is read in the same cycle, so a waiting result holds off the next request. After
// reset a clearing pass over max(HOLDING_DEPTH, INPUT_DEPTH) addresses zeroes both register
// memories before the first request is taken; configuration writes are taken at any time.
`include "modbus_rtu_register_slave_core_defines.svh"
module modbus_rtu_register_slave_core #(
	parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF,
	parameter int HOLDING_DEPTH = mrs_pkg::HOLDING_DEPTH_DEF,
	parameter int INPUT_DEPTH   = mrs_pkg::INPUT_DEPTH_DEF,
	parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mrs_pkg::mrs_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mrs_pkg::mrs_rsp_t rsp_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_data
);
	import mrs_pkg::*;

	mrs_cmd_t    cmd;
	mrs_status_t st;

	assign cfg_ready = 1'b1;

	mrs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_operation (req_data.operation),
		.req_frame_end (req_data.frame_end),
		.req_ready     (req_ready),
		.st            (st),
		.cmd           (cmd)
	);

	mrs_datapath #(
		.FRAME_BYTES   (FRAME_BYTES),
		.HOLDING_DEPTH (HOLDING_DEPTH),
		.INPUT_DEPTH   (INPUT_DEPTH),
		.MAX_READ_REGS (MAX_READ_REGS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

	`MRS_ASSERT_IMPL(a_emit_slot_free, cmd.emit, st.out_free)
	`MRS_ASSERT_IMPL(a_ready_slot_free, req_ready, st.out_free)
	`MRS_ASSERT_IMPL(a_inner_byte_is_reply, rsp_valid && !rsp_data.tx_last, rsp_data.outcome == OC_NORMAL || rsp_data.outcome == OC_EXCEPTION)
	`MRS_ASSERT_NEXT(a_status_follows, req_valid && req_ready && req_data.operation != OP_HOLD_RD && !(req_data.operation == OP_BUS && req_data.frame_end), rsp_valid)

endmodule
